FILE: rtl/suks_pkg.sv
// Shared constants for the sorted unique key set unit.
package suks_pkg;

	// Default sizing
	localparam int CAPACITY_DEF = 16;
	localparam int KEY_BITS_DEF = 14;

	// Range register reset values
	localparam int KEY_MIN_RST = 1000;
	localparam int KEY_MAX_RST = 9999;

	// Field widths fixed by the result format
	localparam int OPC_W     = 2;
	localparam int STATUS_W  = 3;
	localparam int CNT_OUT_W = 5;
	localparam int POS_W     = 4;
	localparam int CFG_IDX_W = 1;

	// Opcodes
	localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OPC_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OPC_W-1:0] OP_CLEAR  = 2'd2;
	localparam logic [OPC_W-1:0] OP_LIST   = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_MIN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_MAX = 1'd1;

endpackage

FILE: rtl/suks_if.sv
// Command and response channel interfaces of the sorted unique key set unit.
interface suks_cmd_if #(
	parameter int KEY_BITS = suks_pkg::KEY_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic [suks_pkg::OPC_W-1:0]  opcode;
	logic [KEY_BITS-1:0]         key;

	modport source (output valid, output opcode, output key, input ready);
	modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface suks_rsp_if #(
	parameter int KEY_BITS = suks_pkg::KEY_BITS_DEF
);
	logic                            valid;
	logic                            ready;
	logic [suks_pkg::STATUS_W-1:0]   status;
	logic [suks_pkg::CNT_OUT_W-1:0]  entry_count;
	logic [KEY_BITS-1:0]             entry_value;
	logic [suks_pkg::POS_W-1:0]      entry_position;
	logic                            last;

	modport source (output valid, output status, output entry_count, output entry_value,
		output entry_position, output last, input ready);
	modport sink   (input valid, input status, input entry_count, input entry_value,
		input entry_position, input last, output ready);
endinterface

FILE: rtl/suks_ram.sv
// Generic single write port, single read port RAM with registered read data.
module suks_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/sorted_unique_key_set_unit.sv
// Sorted unique key set: holds up to CAPACITY distinct keys in ascending order in a
// single-port-read RAM. One command is taken at a time; cmd.ready is high only while
// the sequencer is idle. Every RAM access goes through one registered read port and
// one key comparator, so each entry visited takes a read state and a compare state.
// Insert scans entries until the sorted slot is found, shifts each entry above it up
// with a read and a write, then places the key and posts the result. Remove scans,
// shifts each entry above the match down, then posts. Clear and the rejected cases
// (full, empty, out of range) go straight to posting. List gives one result per held
// key, each posted after its read and compare, plus any response stall. A result
// sits in an output register, so a new command may be taken while the last result
// waits for its transfer. Clear and reset only zero the fill count: slots at or
// beyond the count are never read, so no clearing pass runs.
module sorted_unique_key_set_unit #(
	parameter int CAPACITY = suks_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = suks_pkg::KEY_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [suks_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [KEY_BITS-1:0]            cfg_data,
	suks_cmd_if.sink                       cmd,
	suks_rsp_if.source                     rsp
);
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int ST_W  = 4;

	// Sequencer states
	localparam logic [ST_W-1:0] S_IDLE    = 4'd0;
	localparam logic [ST_W-1:0] S_INS_RD  = 4'd1;  // insert: read slot idx
	localparam logic [ST_W-1:0] S_INS_CMP = 4'd2;  // insert: compare slot idx
	localparam logic [ST_W-1:0] S_SHU_RD  = 4'd3;  // shift up: read slot j-1
	localparam logic [ST_W-1:0] S_SHU_WR  = 4'd4;  // shift up: write slot j
	localparam logic [ST_W-1:0] S_PUT     = 4'd5;  // write new key at pos
	localparam logic [ST_W-1:0] S_RM_RD   = 4'd6;
	localparam logic [ST_W-1:0] S_RM_CMP  = 4'd7;
	localparam logic [ST_W-1:0] S_SHD_RD  = 4'd8;  // shift down: read slot j+1
	localparam logic [ST_W-1:0] S_SHD_WR  = 4'd9;  // shift down: write slot j
	localparam logic [ST_W-1:0] S_LST_RD  = 4'd10;
	localparam logic [ST_W-1:0] S_LST_CMP = 4'd11;
	localparam logic [ST_W-1:0] S_EMIT    = 4'd12; // post result to output register

	logic [ST_W-1:0]               state_q;
	logic [ST_W-1:0]               ret_q;     // state to enter after the result posts
	logic [IDX_W-1:0]              idx_q;     // scan index, also j during shifts
	logic [IDX_W-1:0]              pos_q;     // insert slot
	logic [CNT_W-1:0]              cnt_q;
	logic [KEY_BITS-1:0]           key_q;
	logic [KEY_BITS-1:0]           key_min_q;
	logic [KEY_BITS-1:0]           key_max_q;

	// Pending result
	logic [suks_pkg::STATUS_W-1:0] res_status_q;
	logic [KEY_BITS-1:0]           res_value_q;
	logic [IDX_W-1:0]              res_pos_q;
	logic                          res_last_q;

	// Output register
	logic                           out_vld_q;
	logic [suks_pkg::STATUS_W-1:0]  out_status_q;
	logic [suks_pkg::CNT_OUT_W-1:0] out_count_q;
	logic [KEY_BITS-1:0]            out_value_q;
	logic [suks_pkg::POS_W-1:0]     out_pos_q;
	logic                           out_last_q;

	// RAM port
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [KEY_BITS-1:0] ram_wdata;
	logic [IDX_W-1:0]    ram_raddr;
	logic [KEY_BITS-1:0] ram_rdata;

	logic cmd_xfer;
	logic out_free;
	logic in_range;
	logic key_eq;
	logic key_gt;
	logic idx_last;
	logic shd_done;

	suks_ram #(
		.WIDTH(KEY_BITS),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_xfer  = cmd.valid && cmd.ready;
	assign out_free  = !out_vld_q || rsp.ready;
	assign in_range  = (cmd.key >= key_min_q) && (cmd.key <= key_max_q);

	// The shared comparator: RAM read data against the command key.
	assign key_eq = (ram_rdata == key_q);
	assign key_gt = (ram_rdata > key_q);

	// idx is the last used slot; j+1 is the last used slot during a shift down
	assign idx_last = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);
	assign shd_done = ((CNT_W'(idx_q) + CNT_W'(2)) == cnt_q);

	assign rsp.valid          = out_vld_q;
	assign rsp.status         = out_status_q;
	assign rsp.entry_count    = out_count_q;
	assign rsp.entry_value    = out_value_q;
	assign rsp.entry_position = out_pos_q;
	assign rsp.last           = out_last_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata;
		ram_raddr = idx_q;
		case (state_q)
			S_SHU_RD: begin
				ram_raddr = idx_q - IDX_W'(1);
			end
			S_SHU_WR: begin
				ram_we = 1'b1;
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = key_q;
			end
			S_SHD_RD: begin
				ram_raddr = idx_q + IDX_W'(1);
			end
			S_SHD_WR: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Range registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_min_q <= KEY_BITS'(suks_pkg::KEY_MIN_RST);
			key_max_q <= KEY_BITS'(suks_pkg::KEY_MAX_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				suks_pkg::CFG_KEY_MIN: key_min_q <= cfg_data;
				suks_pkg::CFG_KEY_MAX: key_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ret_q        <= S_IDLE;
			idx_q        <= '0;
			pos_q        <= '0;
			cnt_q        <= '0;
			key_q        <= '0;
			res_status_q <= suks_pkg::ST_OK;
			res_value_q  <= '0;
			res_pos_q    <= '0;
			res_last_q   <= 1'b0;
			out_vld_q    <= 1'b0;
			out_status_q <= suks_pkg::ST_OK;
			out_count_q  <= '0;
			out_value_q  <= '0;
			out_pos_q    <= '0;
			out_last_q   <= 1'b0;
		end else begin
			// a posted result refills the register, else a transfer empties it
			if (state_q == S_EMIT && out_free) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (cmd_xfer) begin
						key_q        <= cmd.key;
						idx_q        <= '0;
						res_value_q  <= '0;
						res_pos_q    <= '0;
						res_last_q   <= 1'b1;
						res_status_q <= suks_pkg::ST_OK;
						ret_q        <= S_IDLE;
						case (cmd.opcode)
							suks_pkg::OP_INSERT: begin
								if (cnt_q == CNT_W'(CAPACITY)) begin
									res_status_q <= suks_pkg::ST_FULL;
									state_q      <= S_EMIT;
								end else if (!in_range) begin
									res_status_q <= suks_pkg::ST_RANGE;
									state_q      <= S_EMIT;
								end else if (cnt_q == '0) begin
									pos_q   <= '0;
									state_q <= S_PUT;
								end else begin
									state_q <= S_INS_RD;
								end
							end
							suks_pkg::OP_REMOVE: begin
								if (cnt_q == '0) begin
									res_status_q <= suks_pkg::ST_EMPTY;
									state_q      <= S_EMIT;
								end else if (!in_range) begin
									res_status_q <= suks_pkg::ST_RANGE;
									state_q      <= S_EMIT;
								end else begin
									state_q <= S_RM_RD;
								end
							end
							suks_pkg::OP_CLEAR: begin
								cnt_q   <= '0;
								state_q <= S_EMIT;
							end
							default: begin
								if (cnt_q == '0) begin
									res_status_q <= suks_pkg::ST_EMPTY;
									state_q      <= S_EMIT;
								end else begin
									state_q <= S_LST_RD;
								end
							end
						endcase
					end
				end
				S_INS_RD: begin
					state_q <= S_INS_CMP;
				end
				S_INS_CMP: begin
					if (key_eq) begin
						res_status_q <= suks_pkg::ST_DUP;
						state_q      <= S_EMIT;
					end else if (key_gt) begin
						// first larger key: open a gap here, moving from the top down
						pos_q   <= idx_q;
						idx_q   <= IDX_W'(cnt_q);
						state_q <= S_SHU_RD;
					end else if (idx_last) begin
						pos_q   <= IDX_W'(cnt_q);
						state_q <= S_PUT;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_INS_RD;
					end
				end
				S_SHU_RD: begin
					state_q <= S_SHU_WR;
				end
				S_SHU_WR: begin
					if ((idx_q - IDX_W'(1)) == pos_q) begin
						state_q <= S_PUT;
					end else begin
						idx_q   <= idx_q - IDX_W'(1);
						state_q <= S_SHU_RD;
					end
				end
				S_PUT: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= S_EMIT;
				end
				S_RM_RD: begin
					state_q <= S_RM_CMP;
				end
				S_RM_CMP: begin
					if (key_eq) begin
						if (idx_last) begin
							cnt_q   <= cnt_q - CNT_W'(1);
							state_q <= S_EMIT;
						end else begin
							state_q <= S_SHD_RD;
						end
					end else if (key_gt || idx_last) begin
						// sorted order: past the key means it is absent
						res_status_q <= suks_pkg::ST_NOTFOUND;
						state_q      <= S_EMIT;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_RM_RD;
					end
				end
				S_SHD_RD: begin
					state_q <= S_SHD_WR;
				end
				S_SHD_WR: begin
					// vacated top slot is left stale; it lies beyond the count
					if (shd_done) begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= S_EMIT;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_SHD_RD;
					end
				end
				S_LST_RD: begin
					state_q <= S_LST_CMP;
				end
				S_LST_CMP: begin
					res_status_q <= suks_pkg::ST_OK;
					res_value_q  <= ram_rdata;
					res_pos_q    <= idx_q;
					res_last_q   <= idx_last;
					ret_q        <= idx_last ? S_IDLE : S_LST_RD;
					state_q      <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_count_q  <= suks_pkg::CNT_OUT_W'(cnt_q);
						out_value_q  <= res_value_q;
						out_pos_q    <= suks_pkg::POS_W'(res_pos_q);
						out_last_q   <= res_last_q;
						state_q      <= ret_q;
						if (ret_q == S_LST_RD) begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

FILE: rtl/suks_chk.sv
// Port-level checker for the sorted unique key set unit, with its bind.
module suks_chk #(
	parameter int CAPACITY = suks_pkg::CAPACITY_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cmd_valid,
	input logic                           cmd_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [suks_pkg::STATUS_W-1:0]  status,
	input logic [suks_pkg::CNT_OUT_W-1:0] entry_count,
	input logic                           last
);
	// Only list entries ahead of the final one are non-last, and they are all ok.
	a_nonlast_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !last |-> status == suks_pkg::ST_OK && entry_count != '0)
		else $error("non-final result with bad status or zero count");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == suks_pkg::ST_EMPTY |-> entry_count == '0 && last)
		else $error("empty status with nonzero count or not last");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == suks_pkg::ST_FULL
			|-> entry_count == suks_pkg::CNT_OUT_W'(CAPACITY))
		else $error("full status without a full set");

	// A command transfer takes ready low, as the sequencer leaves idle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("ready right after a command transfer");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(last))
		else $error("stalled result changed");
endmodule

bind sorted_unique_key_set_unit suks_chk #(
	.CAPACITY(CAPACITY)
) u_suks_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.entry_count (rsp.entry_count),
	.last        (rsp.last)
);

FILE: verif/sorted_unique_key_set_unit_test.sv
// Self-checking testbench for the sorted unique key set unit: directed table then random traffic.
`timescale 1ns / 100ps

module sorted_unique_key_set_unit_test;

	localparam int CAPACITY  = suks_pkg::CAPACITY_DEF;
	localparam int KEY_BITS  = suks_pkg::KEY_BITS_DEF;
	// Watchdog, meant to sit above the slowest legal run (every list at 16 results, each
	// result held off by the longest ready stall, every command behind the longest valid gap).
	localparam int CYCLE_LIMIT = 1_000_000;
	// Quiet time after the last expected transfer, to catch any stray result.
	localparam int DRAIN_CYCLES = 80;
	localparam int NUM_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 33;
	localparam int NUM_DIRECTED = 22;

	// One response beat as the block should present it.
	typedef struct {
		logic [suks_pkg::STATUS_W-1:0]  status;
		logic [suks_pkg::CNT_OUT_W-1:0] count;
		logic [KEY_BITS-1:0]            value;
		logic [suks_pkg::POS_W-1:0]     position;
		logic                           last;
	} set_result_t;

	// One row of the directed table. When pinned is set, status and count are typed in and
	// replace the predicted ones; otherwise the predictor alone decides.
	typedef struct {
		logic [suks_pkg::OPC_W-1:0]     op;
		logic [KEY_BITS-1:0]            key;
		bit                             pinned;
		logic [suks_pkg::STATUS_W-1:0]  status;
		logic [suks_pkg::CNT_OUT_W-1:0] count;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic                           cfg_we;
	logic [suks_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [KEY_BITS-1:0]            cfg_data;

	suks_cmd_if #(.KEY_BITS(KEY_BITS)) cmd_ch ();
	suks_rsp_if #(.KEY_BITS(KEY_BITS)) rsp_ch ();

	sorted_unique_key_set_unit #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch)
	);

	// Shadow copy of the set and of the range registers.
	logic [KEY_BITS-1:0] held_keys [CAPACITY];
	int                  held_count;
	logic [KEY_BITS-1:0] range_lo;
	logic [KEY_BITS-1:0] range_hi;

	// Results still owed by the block, oldest first.
	set_result_t pending_results [$];

	int  mismatch_count;
	int  cycle_count;
	// When set, neither side inserts gaps.
	bit  no_idle;

	// Directed table, run from reset values (range 1000..9999, empty set).
	stim_row_t directed_rows [NUM_DIRECTED] = '{
		'{suks_pkg::OP_LIST,   14'd0,     1'b1, suks_pkg::ST_EMPTY,    5'd0},  // empty list
		'{suks_pkg::OP_REMOVE, 14'd5000,  1'b1, suks_pkg::ST_EMPTY,    5'd0},  // empty remove
		'{suks_pkg::OP_INSERT, 14'd999,   1'b1, suks_pkg::ST_RANGE,    5'd0},  // below minimum
		'{suks_pkg::OP_INSERT, 14'd10000, 1'b1, suks_pkg::ST_RANGE,    5'd0},  // above maximum
		'{suks_pkg::OP_INSERT, 14'd0,     1'b1, suks_pkg::ST_RANGE,    5'd0},
		'{suks_pkg::OP_INSERT, 14'd1000,  1'b1, suks_pkg::ST_OK,       5'd1},  // minimum itself
		'{suks_pkg::OP_INSERT, 14'd9999,  1'b1, suks_pkg::ST_OK,       5'd2},  // maximum itself
		'{suks_pkg::OP_INSERT, 14'd1000,  1'b1, suks_pkg::ST_DUP,      5'd2},
		'{suks_pkg::OP_INSERT, 14'd16383, 1'b1, suks_pkg::ST_RANGE,    5'd2},
		'{suks_pkg::OP_INSERT, 14'd5000,  1'b0, suks_pkg::ST_OK,       5'd0},
		'{suks_pkg::OP_INSERT, 14'd3000,  1'b0, suks_pkg::ST_OK,       5'd0},  // mid-set
		'{suks_pkg::OP_LIST,   14'd16383, 1'b0, suks_pkg::ST_OK,       5'd0},
		'{suks_pkg::OP_REMOVE, 14'd4000,  1'b1, suks_pkg::ST_NOTFOUND, 5'd4},
		'{suks_pkg::OP_REMOVE, 14'd16383, 1'b1, suks_pkg::ST_RANGE,    5'd4},
		'{suks_pkg::OP_REMOVE, 14'd0,     1'b1, suks_pkg::ST_RANGE,    5'd4},
		'{suks_pkg::OP_REMOVE, 14'd3000,  1'b0, suks_pkg::ST_OK,       5'd0},  // middle entry
		'{suks_pkg::OP_REMOVE, 14'd1000,  1'b0, suks_pkg::ST_OK,       5'd0},  // first entry
		'{suks_pkg::OP_REMOVE, 14'd9999,  1'b0, suks_pkg::ST_OK,       5'd0},  // last entry
		'{suks_pkg::OP_LIST,   14'd0,     1'b0, suks_pkg::ST_OK,       5'd0},
		'{suks_pkg::OP_CLEAR,  14'd16383, 1'b1, suks_pkg::ST_OK,       5'd0},
		'{suks_pkg::OP_LIST,   14'd0,     1'b1, suks_pkg::ST_EMPTY,    5'd0},
		'{suks_pkg::OP_REMOVE, 14'd5000,  1'b1, suks_pkg::ST_EMPTY,    5'd0}   // cleared key
	};

	// 10 ns clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Gap length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic bit key_in_range(logic [KEY_BITS-1:0] key);
		return (key >= range_lo) && (key <= range_hi);
	endfunction

	function automatic int find_held(logic [KEY_BITS-1:0] key);
		for (int i = 0; i < held_count; i++)
			if (held_keys[i] == key)
				return i;
		return -1;
	endfunction

	// Key source for random traffic: biased toward hits on the range and on held keys.
	function automatic logic [KEY_BITS-1:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			if (range_lo <= range_hi)
				return KEY_BITS'($urandom_range(int'(range_hi), int'(range_lo)));
			return KEY_BITS'($urandom);
		end
		if (r < 60 && held_count > 0)
			return held_keys[$urandom_range(0, held_count - 1)];
		if (r < 75) begin
			case ($urandom_range(0, 3))
				0: return range_lo;
				1: return range_hi;
				2: return range_lo - 1'b1;
				default: return range_hi + 1'b1;
			endcase
		end
		return KEY_BITS'($urandom);
	endfunction

	// Apply one accepted command to the shadow set and queue what the block owes for it.
	task automatic predict_results(
		input logic [suks_pkg::OPC_W-1:0]     op,
		input logic [KEY_BITS-1:0]            key,
		input bit                             pinned,
		input logic [suks_pkg::STATUS_W-1:0]  pin_status,
		input logic [suks_pkg::CNT_OUT_W-1:0] pin_count
	);
		set_result_t                   res;
		logic [suks_pkg::STATUS_W-1:0] st;
		int                            slot;
		st = suks_pkg::ST_OK;
		res = '{status: suks_pkg::ST_OK, count: '0, value: '0, position: '0, last: 1'b1};
		case (op)
			suks_pkg::OP_INSERT: begin
				// full wins over range, range over duplicate
				if (held_count >= CAPACITY)
					st = suks_pkg::ST_FULL;
				else if (!key_in_range(key))
					st = suks_pkg::ST_RANGE;
				else if (find_held(key) >= 0)
					st = suks_pkg::ST_DUP;
				else begin
					slot = 0;
					while (slot < held_count && held_keys[slot] < key)
						slot++;
					for (int i = held_count; i > slot; i--)
						held_keys[i] = held_keys[i-1];
					held_keys[slot] = key;
					held_count++;
				end
			end
			suks_pkg::OP_REMOVE: begin
				// empty wins over range, range over not found
				if (held_count == 0)
					st = suks_pkg::ST_EMPTY;
				else if (!key_in_range(key))
					st = suks_pkg::ST_RANGE;
				else begin
					slot = find_held(key);
					if (slot < 0)
						st = suks_pkg::ST_NOTFOUND;
					else begin
						for (int i = slot; i + 1 < held_count; i++)
							held_keys[i] = held_keys[i+1];
						held_count--;
						held_keys[held_count] = '0;
					end
				end
			end
			suks_pkg::OP_CLEAR: begin
				for (int i = 0; i < CAPACITY; i++)
					held_keys[i] = '0;
				held_count = 0;
			end
			default: begin
				if (held_count == 0)
					st = suks_pkg::ST_EMPTY;
			end
		endcase

		if (op == suks_pkg::OP_LIST && held_count > 0) begin
			// one beat per held key, ascending, last on the final one
			for (int i = 0; i < held_count; i++) begin
				res.status   = suks_pkg::ST_OK;
				res.count    = suks_pkg::CNT_OUT_W'(held_count);
				res.value    = held_keys[i];
				res.position = suks_pkg::POS_W'(i);
				res.last     = (i + 1 == held_count);
				pending_results.push_back(res);
			end
		end else begin
			res.status = pinned ? pin_status : st;
			res.count  = pinned ? pin_count : suks_pkg::CNT_OUT_W'(held_count);
			pending_results.push_back(res);
		end
	endtask

	// Present one command after a random gap and hold it until the transfer happens.
	// Entered and left at a falling edge.
	task automatic send_command(
		input logic [suks_pkg::OPC_W-1:0]     op,
		input logic [KEY_BITS-1:0]            key,
		input bit                             pinned,
		input logic [suks_pkg::STATUS_W-1:0]  pin_status,
		input logic [suks_pkg::CNT_OUT_W-1:0] pin_count
	);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid  <= 1'b1;
		cmd_ch.opcode <= op;
		cmd_ch.key    <= key;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		predict_results(op, key, pinned, pin_status, pin_count);
		@(negedge clk);
	endtask

	// Let the block run dry before touching the range registers.
	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// Write both range registers on back-to-back cycles. Entered and left at a falling edge.
	task automatic write_ranges(input logic [KEY_BITS-1:0] lo, input logic [KEY_BITS-1:0] hi);
		cfg_we    <= 1'b1;
		cfg_index <= suks_pkg::CFG_KEY_MIN;
		cfg_data  <= lo;
		@(posedge clk);
		range_lo = lo;
		@(negedge clk);
		cfg_index <= suks_pkg::CFG_KEY_MAX;
		cfg_data  <= hi;
		@(posedge clk);
		range_hi = hi;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic report_field(
		input string       name,
		input logic [31:0] exp_val,
		input logic [31:0] got_val
	);
		if (exp_val !== got_val) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_val, got_val);
			mismatch_count++;
		end
	endtask

	// Response checker: every transfer is matched against the oldest owed result.
	always @(posedge clk) begin
		set_result_t exp_res;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: status %0d count %0d value %0d pos %0d last %0d",
					$time, rsp_ch.status, rsp_ch.entry_count, rsp_ch.entry_value,
					rsp_ch.entry_position, rsp_ch.last);
				mismatch_count++;
			end else begin
				exp_res = pending_results.pop_front();
				report_field("status", 32'(exp_res.status), 32'(rsp_ch.status));
				report_field("entry_count", 32'(exp_res.count), 32'(rsp_ch.entry_count));
				report_field("entry_value", 32'(exp_res.value), 32'(rsp_ch.entry_value));
				report_field("entry_position", 32'(exp_res.position),
					32'(rsp_ch.entry_position));
				report_field("last", 32'(exp_res.last), 32'(rsp_ch.last));
			end
		end
	end

	// Response ready: random stalls between random runs of ready.
	initial begin
		int gap;
		rsp_ch.ready = 1'b0;
		@(negedge clk);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	end

	initial begin
		logic [suks_pkg::OPC_W-1:0] op;
		logic [KEY_BITS-1:0]        lo;
		logic [KEY_BITS-1:0]        hi;
		int                         r;

		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = suks_pkg::CFG_KEY_MIN;
		cfg_data      = '0;
		cmd_ch.valid  = 1'b0;
		cmd_ch.opcode = suks_pkg::OP_INSERT;
		cmd_ch.key    = '0;
		mismatch_count = 0;
		cycle_count    = 0;
		no_idle        = 1'b0;
		held_count     = 0;
		for (int i = 0; i < CAPACITY; i++)
			held_keys[i] = '0;
		range_lo = KEY_BITS'(suks_pkg::KEY_MIN_RST);
		range_hi = KEY_BITS'(suks_pkg::KEY_MAX_RST);

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table against reset ranges
		foreach (directed_rows[i])
			send_command(directed_rows[i].op, directed_rows[i].key, directed_rows[i].pinned,
				directed_rows[i].status, directed_rows[i].count);

		// Random phases, each under its own range setting. The set carries over.
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin lo = '0; hi = '1; end                       // whole key space
				1: begin                                             // narrow: fills the set
					lo = KEY_BITS'($urandom_range(0, 16383 - 23));
					hi = lo + 14'd23;
				end
				2: begin                                             // single legal key
					lo = KEY_BITS'($urandom);
					hi = lo;
				end
				3: begin                                             // inverted, no key in range
					lo = KEY_BITS'($urandom_range(8192, 16383));
					hi = KEY_BITS'($urandom_range(0, 8191));
				end
				4: begin lo = 14'd16360; hi = '1; end                // narrow at the top
				default: begin
					lo = KEY_BITS'($urandom);
					hi = KEY_BITS'($urandom);
				end
			endcase
			wait_idle();
			write_ranges(lo, hi);
			// one phase runs at full rate on both sides
			no_idle = (p == 2);

			repeat (ITEMS_PER_PHASE) begin
				r = $urandom_range(0, 99);
				if (r < 45)
					op = suks_pkg::OP_INSERT;
				else if (r < 75)
					op = suks_pkg::OP_REMOVE;
				else if (r < 88)
					op = suks_pkg::OP_LIST;
				else if (r < 91)
					op = suks_pkg::OP_CLEAR;
				else
					op = suks_pkg::OPC_W'($urandom);
				send_command(op, pick_key(), 1'b0, suks_pkg::ST_OK, '0);
			end
		end

		// Drain, then give the block time to show any extra result.
		no_idle = 1'b0;
		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
